FILE: rtl/mbw_pkg.sv
package mbw_pkg;

    // Walk phase of the box parser; the unused code behaves as done.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } walk_phase_t;

    // Record kinds.
    localparam logic KIND_BOX  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Reasons carried by a walk finished record.
    localparam logic [2:0] STOP_EXACT_END   = 3'd0;
    localparam logic [2:0] STOP_SHORT_TAIL  = 3'd1;
    localparam logic [2:0] STOP_LARGE_CUT   = 3'd2;
    localparam logic [2:0] STOP_SIZE_SMALL  = 3'd3;
    localparam logic [2:0] STOP_OVERRUN     = 3'd4;

    // Header lengths and special size codes.
    localparam logic [4:0]  HDR_LEN_NORMAL = 5'd8;
    localparam logic [4:0]  HDR_LEN_LARGE  = 5'd16;
    localparam logic [31:0] SIZE_LARGE     = 32'd1;
    localparam logic [31:0] SIZE_TO_END    = 32'd0;

    // Record queue geometry.
    localparam int REC_QUEUE_DEPTH = 4;
    localparam int QPTR_W          = 2;
    localparam int QCNT_W          = 3;

    // Configuration port.
    localparam int         CFG_ADDR_W            = 3;
    localparam logic       CFG_REG_BUFFER_LENGTH = 1'b0;

    // One result record.
    typedef struct packed {
        logic        record_kind;
        logic [31:0] box_type;
        logic [31:0] body_offset;
        logic [31:0] body_length;
        logic [4:0]  header_length;
        logic [31:0] box_count;
        logic [2:0]  stop_reason;
        logic        last_record;
    } rec_t;

    // Records produced by one byte, in order.
    typedef struct packed {
        logic [1:0] n;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

    // Queue status seen by the walker.
    typedef struct packed {
        logic room_for_two;
    } qstat_t;

endpackage

FILE: rtl/mbw_byte_if.sv
interface mbw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

FILE: rtl/mbw_rec_if.sv
interface mbw_rec_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [31:0] box_type;
    logic [31:0] body_offset;
    logic [31:0] body_length;
    logic [4:0]  header_length;
    logic [31:0] box_count;
    logic [2:0]  stop_reason;
    logic        last_record;

    modport source (
        output valid, output record_kind, output box_type, output body_offset,
        output body_length, output header_length, output box_count,
        output stop_reason, output last_record, input ready
    );
    modport sink (
        input valid, input record_kind, input box_type, input body_offset,
        input body_length, input header_length, input box_count,
        input stop_reason, input last_record, output ready
    );
endinterface

FILE: rtl/mbw_cfg_regs.sv
module mbw_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [31:0]                     buffer_length
);
    import mbw_pkg::*;

    logic [31:0] buffer_length_reg;
    logic        wr_en;
    logic        sel_len;

    // Word index decode: the length register is the only one.
    assign sel_len = (paddr[2] == CFG_REG_BUFFER_LENGTH);
    assign wr_en   = psel && penable && pwrite && sel_len;
    assign pready  = 1'b1;

    // Register write at the access phase of a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= '0;
        end
        else if (wr_en)
        begin
            buffer_length_reg <= pwdata;
        end
    end

    // Read back.
    assign prdata        = sel_len ? buffer_length_reg : 32'd0;
    assign buffer_length = buffer_length_reg;

endmodule

FILE: rtl/mbw_rec_queue.sv
module mbw_rec_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  mbw_pkg::push_t  push,
    output mbw_pkg::qstat_t qstat,
    mbw_rec_if.source       records
);
    import mbw_pkg::*;

    rec_t              mem_reg [REC_QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic              pop;
    rec_t              head;

    assign pop          = records.valid && records.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign qstat.room_for_two = (count_reg <= QCNT_W'(REC_QUEUE_DEPTH - 2));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.n);
        rd_ptr_next = pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage: up to two records land per cycle.
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.rec1;
        end
    end

    // Head of the queue drives the result channel.
    assign head                  = mem_reg[rd_ptr_reg];
    assign records.valid         = (count_reg != '0);
    assign records.record_kind   = head.record_kind;
    assign records.box_type      = head.box_type;
    assign records.body_offset   = head.body_offset;
    assign records.body_length   = head.body_length;
    assign records.header_length = head.header_length;
    assign records.box_count     = head.box_count;
    assign records.stop_reason   = head.stop_reason;
    assign records.last_record   = head.last_record;

    // The fill level never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(REC_QUEUE_DEPTH))
        else $error("record queue overfilled");

    // Records are only written when two slots are free.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> count_reg <= QCNT_W'(REC_QUEUE_DEPTH - 2))
        else $error("record push without room");

    // Pointers and fill level stay consistent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || (count_reg == QCNT_W'(REC_QUEUE_DEPTH))
        |-> wr_ptr_reg == rd_ptr_reg)
        else $error("record queue pointers out of step");

endmodule

FILE: rtl/mbw_walk_core.sv
module mbw_walk_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     buffer_length,
    input  mbw_pkg::qstat_t qstat,
    output mbw_pkg::push_t  push,
    mbw_byte_if.sink        bytes
);
    import mbw_pkg::*;

    // Input register.
    logic                   hold_valid_reg;
    logic [7:0]             hold_byte_reg;
    logic                   hold_first_reg;
    logic                   advance;
    logic                   take;

    // Walk state.
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic [OFFSET_BITS-1:0] end_reg,   end_next;
    logic [4:0]             hdr_reg,   hdr_next;
    logic [31:0]            size_reg,  size_next;
    logic [31:0]            type_reg,  type_next;
    logic [63:0]            large_reg, large_next;
    walk_phase_t            phase_reg, phase_next;
    logic [31:0]            count_reg, count_next;

    // Working values.
    logic [OFFSET_BITS-1:0] pos_c, end_c, end_new;
    logic [4:0]             hdr_c, hb1;
    logic [31:0]            size_c, type_c, count_c, count_inc;
    logic [63:0]            large_c;
    walk_phase_t            phase_c;
    logic [63:0]            len64, cur64, room64, total;
    logic [4:0]             hlen;
    logic                   do_check;
    logic [3:0]             t_start, t_next;

    // Header-start test: bit 3 set when the walk ends, low bits give the reason.
    function automatic logic [3:0] header_test(input logic [63:0] c, input logic [63:0] len);
        logic [3:0] r;
        if (c >= len)
        begin
            r = {1'b1, STOP_EXACT_END};
        end
        else if ((len - c) < 64'd8)
        begin
            r = {1'b1, STOP_SHORT_TAIL};
        end
        else
        begin
            r = 4'd0;
        end
        return r;
    endfunction

    function automatic rec_t done_rec(input logic [31:0] at, input logic [31:0] cnt,
                                      input logic [2:0] reason);
        rec_t r;
        r.record_kind   = KIND_DONE;
        r.box_type      = 32'd0;
        r.body_offset   = at;
        r.body_length   = 32'd0;
        r.header_length = 5'd0;
        r.box_count     = cnt;
        r.stop_reason   = reason;
        r.last_record   = 1'b1;
        return r;
    endfunction

    // Handshake: the input register refills whenever its byte moves on.
    assign advance     = hold_valid_reg && qstat.room_for_two;
    assign bytes.ready = !hold_valid_reg || advance;
    assign take        = bytes.valid && bytes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            hold_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_byte_reg  <= bytes.data_byte;
            hold_first_reg <= bytes.first_byte;
        end
    end

    // Length as seen at the offset width.
    assign len64 = 64'(OFFSET_BITS'(buffer_length));

    // One byte of the walk.
    always_comb
    begin
        pos_c   = pos_reg;
        end_c   = end_reg;
        hdr_c   = hdr_reg;
        size_c  = size_reg;
        type_c  = type_reg;
        large_c = large_reg;
        phase_c = phase_reg;
        count_c = count_reg;
        if (hold_first_reg)
        begin
            pos_c   = '0;
            end_c   = '0;
            hdr_c   = '0;
            size_c  = '0;
            type_c  = '0;
            large_c = '0;
            phase_c = PH_HEADER;
            count_c = '0;
        end

        pos_next   = pos_reg;
        end_next   = end_reg;
        hdr_next   = hdr_reg;
        size_next  = size_reg;
        type_next  = type_reg;
        large_next = large_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        push       = '0;

        cur64     = 64'(end_c);
        room64    = len64 - cur64;
        t_start   = header_test(64'd0, len64);
        hb1       = hdr_c + 5'd1;
        total     = 64'd0;
        hlen      = HDR_LEN_NORMAL;
        do_check  = 1'b0;
        count_inc = count_c + 32'd1;
        end_new   = end_c;
        t_next    = 4'd0;

        if (advance)
        begin
            pos_next   = pos_c;
            end_next   = end_c;
            hdr_next   = hdr_c;
            size_next  = size_c;
            type_next  = type_c;
            large_next = large_c;
            phase_next = phase_c;
            count_next = count_c;

            if (phase_c == PH_HEADER && hdr_c == 5'd0 && pos_c == '0 && t_start[3])
            begin
                // The walk ends before the first header.
                push.n     = 2'd1;
                push.rec0  = done_rec(32'd0, count_c, t_start[2:0]);
                phase_next = PH_DONE;
            end
            else
            begin
                case (phase_c)
                    PH_HEADER:
                    begin
                        pos_next = pos_c + OFFSET_BITS'(1);
                        hdr_next = hb1;
                        if (hdr_c < 5'd4)
                        begin
                            size_next = {size_c[23:0], hold_byte_reg};
                        end
                        else if (hdr_c < 5'd8)
                        begin
                            type_next = {type_c[23:0], hold_byte_reg};
                        end
                        else
                        begin
                            large_next = {large_c[55:0], hold_byte_reg};
                        end

                        // Size decode at the end of the short or long header.
                        if (hb1 == HDR_LEN_NORMAL)
                        begin
                            if (size_next == SIZE_LARGE)
                            begin
                                if (room64 < 64'd16)
                                begin
                                    push.n     = 2'd1;
                                    push.rec0  = done_rec(32'(cur64), count_c, STOP_LARGE_CUT);
                                    phase_next = PH_DONE;
                                end
                            end
                            else if (size_next == SIZE_TO_END)
                            begin
                                total    = room64;
                                do_check = 1'b1;
                            end
                            else
                            begin
                                total    = 64'(size_next);
                                do_check = 1'b1;
                            end
                        end
                        else if (hb1 == HDR_LEN_LARGE)
                        begin
                            total    = large_next;
                            hlen     = HDR_LEN_LARGE;
                            do_check = 1'b1;
                        end

                        // Box size checks and the box found record.
                        if (do_check)
                        begin
                            end_new = OFFSET_BITS'(cur64 + total);
                            t_next  = header_test(64'(end_new), len64);
                            if (total < 64'(hlen))
                            begin
                                push.n     = 2'd1;
                                push.rec0  = done_rec(32'(cur64), count_c, STOP_SIZE_SMALL);
                                phase_next = PH_DONE;
                            end
                            else if (total > room64)
                            begin
                                push.n     = 2'd1;
                                push.rec0  = done_rec(32'(cur64), count_c, STOP_OVERRUN);
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                count_next               = count_inc;
                                push.n                   = 2'd1;
                                push.rec0.record_kind    = KIND_BOX;
                                push.rec0.box_type       = type_next;
                                push.rec0.body_offset    = 32'(cur64 + 64'(hlen));
                                push.rec0.body_length    = 32'(total - 64'(hlen));
                                push.rec0.header_length  = hlen;
                                push.rec0.box_count      = count_inc;
                                push.rec0.stop_reason    = STOP_EXACT_END;
                                push.rec0.last_record    = 1'b1;
                                end_next                 = end_new;
                                if (total == 64'(hlen))
                                begin
                                    // Empty body: the next header is due now.
                                    phase_next = PH_HEADER;
                                    hdr_next   = 5'd0;
                                    size_next  = '0;
                                    type_next  = '0;
                                    large_next = '0;
                                    if (t_next[3])
                                    begin
                                        push.n                = 2'd2;
                                        push.rec0.last_record = 1'b0;
                                        push.rec1  = done_rec(32'(end_new), count_inc,
                                                              t_next[2:0]);
                                        phase_next = PH_DONE;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_BODY;
                                end
                            end
                        end
                    end

                    PH_BODY:
                    begin
                        pos_next = pos_c + OFFSET_BITS'(1);
                        t_next   = header_test(cur64, len64);
                        if (pos_next == end_c)
                        begin
                            // Last body byte: prepare the next header.
                            phase_next = PH_HEADER;
                            hdr_next   = 5'd0;
                            size_next  = '0;
                            type_next  = '0;
                            large_next = '0;
                            if (t_next[3])
                            begin
                                push.n     = 2'd1;
                                push.rec0  = done_rec(32'(cur64), count_c, t_next[2:0]);
                                phase_next = PH_DONE;
                            end
                        end
                    end

                    default:
                    begin
                        // Walk finished: bytes are dropped until a new buffer.
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            end_reg   <= '0;
            hdr_reg   <= '0;
            size_reg  <= '0;
            type_reg  <= '0;
            large_reg <= '0;
            phase_reg <= PH_HEADER;
            count_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            end_reg   <= end_next;
            hdr_reg   <= hdr_next;
            size_reg  <= size_next;
            type_reg  <= type_next;
            large_reg <= large_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Nothing is produced without a byte moving through.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> push.n == 2'd0)
        else $error("record produced without a byte");

    // A pair of records is always a box followed by the end of the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> push.rec0.record_kind == KIND_BOX &&
                           push.rec1.record_kind == KIND_DONE &&
                           !push.rec0.last_record && push.rec1.last_record)
        else $error("bad record pair");

    // A body is only skipped after a complete header.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> (hdr_reg == HDR_LEN_NORMAL || hdr_reg == HDR_LEN_LARGE))
        else $error("body phase without a full header");

endmodule

FILE: rtl/mp4_box_header_walker.sv
// Channel   Role     Handshake      Payload
// bytes     sink     valid/ready    data_byte[7:0], first_byte
// records   source   valid/ready    record_kind, box_type, body_offset, body_length,
//                                   header_length, box_count, stop_reason, last_record
// apb       slave    psel/penable   buffer_length at byte address 0, pready always high
//
// One byte is taken per clock while the record queue has room; a byte is held in the
// input register, and its records are written into the record queue as it moves on.
// A byte may produce two records; the four-entry record queue absorbs them, and the
// input stalls only while fewer than two queue entries are free.
// Reset is asynchronous and active low and leaves the walk at offset zero.
module mp4_box_header_walker #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    mbw_byte_if.sink                        bytes,
    mbw_rec_if.source                       records
);
    import mbw_pkg::*;

    logic [31:0] buffer_length;
    push_t       push;
    qstat_t      qstat;

    // Configuration register.
    mbw_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .buffer_length (buffer_length)
    );

    // Box walker.
    mbw_walk_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .buffer_length (buffer_length),
        .qstat         (qstat),
        .push          (push),
        .bytes         (bytes)
    );

    // Record queue toward the output channel.
    mbw_rec_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .qstat   (qstat),
        .records (records)
    );

endmodule
